/* rtl/front_middle_back_queue_defines.svh */
// ---------------------------------------------------------------------------
// front_middle_back_queue_defines: assertion macros for the queue checker
// ---------------------------------------------------------------------------
`ifndef FRONT_MIDDLE_BACK_QUEUE_DEFINES_SVH
`define FRONT_MIDDLE_BACK_QUEUE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define FMBQ_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define FMBQ_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

/* rtl/fmbq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmbq_pkg
// Shared constants, codes and types of the front/middle/back queue.
// ---------------------------------------------------------------------------
package fmbq_pkg;

   localparam int CAPACITY = 16;
   localparam int WORD_W   = 32;
   localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = 5;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT  = 3'd0,
      ACT_PUSH_MIDDLE = 3'd1,
      ACT_PUSH_BACK   = 3'd2,
      ACT_POP_FRONT   = 3'd3,
      ACT_POP_MIDDLE  = 3'd4,
      ACT_POP_BACK    = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // per-cell update command
   typedef enum logic [1:0] {
      OP_HOLD  = 2'd0,
      OP_LEFT  = 2'd1,
      OP_RIGHT = 2'd2,
      OP_NEW   = 2'd3
   } cell_op_type;

   localparam word_type EMPTY_WORD = -32'sd1;

endpackage

/* rtl/fmbq_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmbq_cell
// One storage slot of the queue; takes its left or right neighbor's word,
// a new word, or holds.
// ---------------------------------------------------------------------------
module fmbq_cell (
   input  logic                   clock,
   input  fmbq_pkg::cell_op_type  cell_op,
   input  fmbq_pkg::word_type     left_data,
   input  fmbq_pkg::word_type     right_data,
   input  fmbq_pkg::word_type     new_data,
   output fmbq_pkg::word_type     data
);
   import fmbq_pkg::*;

   word_type data_ff;
   word_type data_in;

   always_comb begin
      unique case (cell_op)
         OP_LEFT:  data_in = left_data;
         OP_RIGHT: data_in = right_data;
         OP_NEW:   data_in = new_data;
         default:  data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/fmbq_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmbq_ctrl
// Decodes a request, steers the cell row, tracks the count and registers
// the response.
// ---------------------------------------------------------------------------
module fmbq_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic [2:0]                             req_action,
   input  fmbq_pkg::word_type                     cell_data [fmbq_pkg::CAPACITY],
   output fmbq_pkg::cell_op_type                  cell_op   [fmbq_pkg::CAPACITY],
   output logic                                   rsp_valid,
   output fmbq_pkg::word_type                     rsp_pop_value,
   output logic [1:0]                             rsp_status,
   output logic [fmbq_pkg::COUNT_W-1:0]           rsp_entry_count
);
   import fmbq_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               valid_ff, valid_in;
   word_type           pop_ff, pop_in;
   status_type         status_ff, status_in;

   logic               full, empty;
   logic               do_push, do_pop;
   logic [POS_W-1:0]   pos;
   logic [POS_W-1:0]   last_pos;

   assign full     = (count_ff == COUNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign last_pos = POS_W'(count_ff - COUNT_W'(1));

   always_comb begin
      do_push   = 1'b0;
      do_pop    = 1'b0;
      pos       = '0;
      status_in = ST_DONE;
      unique case (action_type'(req_action))
         ACT_PUSH_FRONT: begin
            do_push = ~full;
            pos     = '0;
         end
         ACT_PUSH_MIDDLE: begin
            do_push = ~full;
            pos     = POS_W'(count_ff >> 1);
         end
         ACT_PUSH_BACK: begin
            do_push = ~full;
            pos     = POS_W'(count_ff);
         end
         ACT_POP_FRONT: begin
            do_pop = ~empty;
            pos    = '0;
         end
         ACT_POP_MIDDLE: begin
            do_pop = ~empty;
            pos    = last_pos >> 1;
         end
         ACT_POP_BACK: begin
            do_pop = ~empty;
            pos    = last_pos;
         end
         default: begin
            do_push = 1'b0;
         end
      endcase

      if ((action_type'(req_action) == ACT_PUSH_FRONT ||
           action_type'(req_action) == ACT_PUSH_MIDDLE ||
           action_type'(req_action) == ACT_PUSH_BACK) && full) begin
         status_in = ST_FULL;
      end else if ((action_type'(req_action) == ACT_POP_FRONT ||
                    action_type'(req_action) == ACT_POP_MIDDLE ||
                    action_type'(req_action) == ACT_POP_BACK) && empty) begin
         status_in = ST_EMPTY;
      end

      if (do_pop) begin
         pop_in = cell_data[pos];
      end else if (status_in == ST_EMPTY) begin
         pop_in = EMPTY_WORD;
      end else begin
         pop_in = '0;
      end
   end

   // steer every cell from the request position
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_op[i] = OP_HOLD;
         if (accept && do_push) begin
            if (POS_W'(i) > pos) begin
               cell_op[i] = OP_LEFT;
            end else if (POS_W'(i) == pos) begin
               cell_op[i] = OP_NEW;
            end
         end else if (accept && do_pop) begin
            if (POS_W'(i) >= pos) begin
               cell_op[i] = OP_RIGHT;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept && do_push) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (accept && do_pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
      valid_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_ff    <= pop_in;
      status_ff <= status_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pop_value   = pop_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;

endmodule

/* rtl/front_middle_back_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// front_middle_back_queue
// Ordered store of signed words with push and pop at front, middle and back.
// ---------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy never rises, so one
// request per clock is sustained. The entries sit in a row of cells; those
// past the request position shift toward or away from it in the same cycle,
// and the response (popped word, status, count after the request) appears
// with rsp_valid in the cycle after the request and is not held.
module front_middle_back_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [2:0]                      req_action,
   input  fmbq_pkg::word_type              req_push_value,
   output logic                            rsp_valid,
   output fmbq_pkg::word_type              rsp_pop_value,
   output logic [1:0]                      rsp_status,
   output logic [fmbq_pkg::COUNT_W-1:0]    rsp_entry_count
);
   import fmbq_pkg::*;

   word_type    cell_data [CAPACITY];
   cell_op_type cell_op   [CAPACITY];
   logic        accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   fmbq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_action      (req_action),
      .cell_data       (cell_data),
      .cell_op         (cell_op),
      .rsp_valid       (rsp_valid),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type left_word;
      word_type right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_mid_l
         assign left_word = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_mid_r
         assign right_word = cell_data[i+1];
      end

      fmbq_cell u_cell (
         .clock      (clock),
         .cell_op    (cell_op[i]),
         .left_data  (left_word),
         .right_data (right_word),
         .new_data   (req_push_value),
         .data       (cell_data[i])
      );
   end

endmodule

/* rtl/fmbq_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmbq_checker
// Port-level checks on the queue's request/response timing and results.
// ---------------------------------------------------------------------------
`include "front_middle_back_queue_defines.svh"

module fmbq_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            rsp_valid,
   input  fmbq_pkg::word_type              rsp_pop_value,
   input  logic [1:0]                      rsp_status,
   input  logic [fmbq_pkg::COUNT_W-1:0]    rsp_entry_count
);
   import fmbq_pkg::*;

   logic req_taken;
   logic empty_rsp_ok;
   logic full_rsp_ok;

   assign req_taken    = start && !busy;
   assign empty_rsp_ok = (rsp_entry_count == '0) && (rsp_pop_value == EMPTY_WORD);
   assign full_rsp_ok  = (rsp_entry_count == COUNT_W'(CAPACITY)) && (rsp_pop_value == '0);

   `FMBQ_ASSERT_NEXT(a_rsp_follows_req, req_taken, rsp_valid, "request without response")
   `FMBQ_ASSERT_NEXT(a_no_spurious_rsp, !req_taken, !rsp_valid, "response without request")
   `FMBQ_ASSERT_NOW(a_empty_pop, rsp_valid && rsp_status == ST_EMPTY, empty_rsp_ok, "bad empty pop")
   `FMBQ_ASSERT_NOW(a_full_push, rsp_valid && rsp_status == ST_FULL, full_rsp_ok, "bad full push")

endmodule

bind front_middle_back_queue fmbq_checker u_fmbq_checker (.*);
